FILE: hw/rtl/gyro_yaw_integrator_assert.svh
// Assertion macros shared by the gyro yaw integrator RTL.
`ifndef GYRO_YAW_INTEGRATOR_ASSERT_SVH
`define GYRO_YAW_INTEGRATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define GYI_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gyro_yaw_integrator: assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define GYI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gyro_yaw_integrator: assertion failed");

`endif

FILE: hw/rtl/gyi_pkg.sv
// Types, codes and constants of the gyro yaw integrator.
package gyi_pkg;

	localparam int CAL_COUNT_BITS_DEF = 16;

	localparam int MIN_INTERVAL_W = 20;
	localparam logic [MIN_INTERVAL_W-1:0] MIN_INTERVAL_RST = 20'd20000;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-3:0] REG_MIN_INTERVAL = '0;

	// Serial multiplier: a narrow multiplicand against a 32-bit multiplier.
	localparam int MUL_A_W = 27;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Integration divides (|diff| * elapsed * 8 + half) by a fixed constant.
	localparam int RATE_NUM_W = 60;
	localparam int RATE_DEN_W = 22;
	localparam logic [RATE_DEN_W-1:0] RATE_DIV  = 22'd2046875;
	localparam logic [RATE_DEN_W-1:0] RATE_HALF = 22'd1023437;
	localparam int DELTA_W = 40;

	// pi/180 in Q32 and the number of fraction bits it carries.
	localparam logic [MUL_A_W-1:0] RAD_Q32 = 27'd74961321;
	localparam int RAD_FRAC = 32;

	typedef enum logic [1:0] {
		ACT_RATE    = 2'd0,
		ACT_CAL     = 2'd1,
		ACT_END_CAL = 2'd2,
		ACT_SET_YAW = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_INTEGRATED   = 3'd0,
		ST_FIRST        = 3'd1,
		ST_TOO_SOON     = 3'd2,
		ST_CAL_SAMPLE   = 3'd3,
		ST_CAL_DONE     = 3'd4,
		ST_CAL_EMPTY_SET = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MUL,
		S_DIV,
		S_RAD,
		S_RAD_WAIT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef struct packed {
		action_t             action;
		logic [31:0]         timestamp;
		logic signed [15:0]  raw_rate;
		logic signed [31:0]  yaw_value;
	} sample_t;

	typedef struct packed {
		logic signed [31:0]  yaw_degrees;
		logic signed [31:0]  yaw_radians;
		logic signed [23:0]  bias;
		status_t             status;
	} result_t;

endpackage

FILE: hw/rtl/gyro_yaw_integrator.sv
// Gyro yaw integrator top level: control, state registers and configuration port.
// Each sample transaction carries one of four actions (rate sample, calibration
// sample, end of calibration, set yaw) and yields exactly one result transaction
// holding the yaw in degrees and radians (signed Q16.16), the rate bias (raw LSB,
// signed Q8) and a status code. The block works on one transaction at a time:
// sample_stall is high from acceptance until the result has been placed in the
// output register, which then waits for the far side independently. The time per
// transaction is set by the two bit-serial units: the shift-and-add multiplier
// takes one bit of the 32-bit multiplier per cycle, the restoring divider one
// dividend bit per cycle. Every transaction ends with a multiplier pass turning
// degrees into radians; a calibration sample, set yaw, first or too-soon rate
// sample or empty end of calibration needs only that pass, an end of calibration
// divides first, and an integrated rate sample multiplies, divides and multiplies
// again. There is no clearing pass after reset. The minimum sample interval
// register sits at byte address 0 of the APB port and reads back zero-extended;
// the user must write it only while the block is idle; the block does not enforce it.

`include "gyro_yaw_integrator_assert.svh"

module gyro_yaw_integrator #(
	parameter int CAL_COUNT_BITS = gyi_pkg::CAL_COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Sample channel.
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  gyi_pkg::sample_t                 sample,
	// Result channel.
	output logic                             result_valid,
	input  logic                             result_stall,
	output gyi_pkg::result_t                 result,
	// Configuration port.
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [gyi_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [gyi_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [gyi_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);

	// Calibration sums and counts scale with CAL_COUNT_BITS; so do the
	// dividend and divisor of the shared divider, which must also hold the
	// fixed integration division.
	localparam int SUM_W     = CAL_COUNT_BITS + 16;
	localparam int CAL_NUM_W = SUM_W + 9;
	localparam int NUM_W     = (CAL_NUM_W > gyi_pkg::RATE_NUM_W) ? CAL_NUM_W
		: gyi_pkg::RATE_NUM_W;
	localparam int DEN_W     = (CAL_COUNT_BITS + 1 > gyi_pkg::RATE_DEN_W)
		? CAL_COUNT_BITS + 1 : gyi_pkg::RATE_DEN_W;
	localparam int MIW       = gyi_pkg::MIN_INTERVAL_W;
	localparam int DW        = gyi_pkg::DELTA_W;

	// Control state.
	gyi_pkg::state_t  state_q, state_d;
	logic             out_valid_q;

	// Architectural state.
	logic [MIW-1:0]            min_interval_q;
	logic [31:0]               yaw_q;
	logic [31:0]               last_stamp_q;
	logic                      stamp_valid_q;
	logic [23:0]               bias_q;
	logic [SUM_W-1:0]          cal_sum_q;
	logic [CAL_COUNT_BITS-1:0] cal_count_q;
	gyi_pkg::status_t          status_q;
	logic                      neg_q;

	// Captured transaction and finished results.
	gyi_pkg::sample_t cur_q;
	logic [31:0]      rad_q;
	gyi_pkg::result_t out_q;

	// Datapath.
	logic [31:0]               elapsed;
	logic                      too_soon;
	logic                      integrate;
	logic [24:0]               diff;
	logic [24:0]               diff_mag;
	logic [31:0]               yaw_mag;
	logic [SUM_W-1:0]          cal_mag;
	logic [SUM_W-1:0]          raw_ext;
	logic                      cal_full;

	logic                          mul_start;
	logic [gyi_pkg::MUL_A_W-1:0]   mul_a;
	logic [gyi_pkg::MUL_B_W-1:0]   mul_b;
	logic [gyi_pkg::MUL_P_W-1:0]   mul_prod;
	gyi_pkg::unit_stat_t           mul_stat;

	logic                 div_start;
	logic [NUM_W-1:0]     div_base;
	logic [NUM_W-1:0]     div_addend;
	logic [NUM_W-1:0]     div_num;
	logic [DEN_W-1:0]     div_den;
	logic [NUM_W-1:0]     div_quot;
	gyi_pkg::unit_stat_t  div_stat;

	logic [DW:0]          delta_mag;
	logic [DW:0]          delta;
	logic [DW:0]          yaw_sum;
	logic [31:0]          yaw_sat;
	logic [23:0]          bias_mag;
	logic [gyi_pkg::MUL_A_W-1:0] rad_mag;
	logic [31:0]          rad_val;
	logic                 out_load;
	logic                 cfg_write;

	// ------------------------------------------------------------------
	// Configuration port. Every access completes in its access cycle.
	// ------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite
		&& (paddr[gyi_pkg::APB_ADDR_W-1:2] == gyi_pkg::REG_MIN_INTERVAL);
	assign prdata    = (paddr[gyi_pkg::APB_ADDR_W-1:2] == gyi_pkg::REG_MIN_INTERVAL)
		? gyi_pkg::APB_DATA_W'(min_interval_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q <= gyi_pkg::MIN_INTERVAL_RST;
		end else if (cfg_write) begin
			min_interval_q <= pwdata[MIW-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Decode arithmetic on the captured transaction.
	// ------------------------------------------------------------------
	// Elapsed time wraps with the 32-bit microsecond counter.
	assign elapsed   = cur_q.timestamp - last_stamp_q;
	assign too_soon  = elapsed < 32'(min_interval_q);
	assign integrate = stamp_valid_q && !too_soon;

	// The rate difference in Q8 LSB needs 25 bits; its magnitude fits 25
	// bits unsigned.
	assign diff     = {cur_q.raw_rate[15], cur_q.raw_rate, 8'h00} - {bias_q[23], bias_q};
	assign diff_mag = diff[24] ? (25'd0 - diff) : diff;
	assign yaw_mag  = yaw_q[31] ? (32'd0 - yaw_q) : yaw_q;
	assign cal_mag  = cal_sum_q[SUM_W-1] ? (SUM_W'(0) - cal_sum_q) : cal_sum_q;
	assign raw_ext  = {{(SUM_W-16){cur_q.raw_rate[15]}}, cur_q.raw_rate};
	assign cal_full = (cal_count_q == '1);

	// The multiplier serves the integration product in the decode state and
	// the degrees-to-radians product otherwise.
	assign mul_a = (state_q == gyi_pkg::S_EXEC) ? gyi_pkg::MUL_A_W'(diff_mag)
		: gyi_pkg::RAD_Q32;
	assign mul_b = (state_q == gyi_pkg::S_EXEC) ? elapsed : yaw_mag;

	// The divider serves the calibration mean (sum * 512 + n) / (2n) and
	// the integration step (product * 8 + half) / constant through one adder.
	always_comb begin
		if (state_q == gyi_pkg::S_EXEC) begin
			div_base   = NUM_W'({cal_mag, 9'h000});
			div_addend = NUM_W'(cal_count_q);
			div_den    = DEN_W'({cal_count_q, 1'b0});
		end else begin
			div_base   = NUM_W'({mul_prod, 3'b000});
			div_addend = NUM_W'(gyi_pkg::RATE_HALF);
			div_den    = DEN_W'(gyi_pkg::RATE_DIV);
		end
	end
	assign div_num = div_base + div_addend;

	gyi_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.stat    (mul_stat),
		.product (mul_prod)
	);

	gyi_serial_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (div_num),
		.den      (div_den),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	// Signed yaw step, rounded away from zero by the divider's half term,
	// then a saturating add to the 32-bit angle.
	assign delta_mag = {1'b0, div_quot[DW-1:0]};
	assign delta     = neg_q ? ((DW+1)'(0) - delta_mag) : delta_mag;
	assign yaw_sum   = {{(DW+1-32){yaw_q[31]}}, yaw_q} + delta;
	always_comb begin
		if ((yaw_sum[DW:31] == '0) || (yaw_sum[DW:31] == '1)) begin
			yaw_sat = yaw_sum[31:0];
		end else if (yaw_sum[DW]) begin
			yaw_sat = 32'h8000_0000;
		end else begin
			yaw_sat = 32'h7fff_ffff;
		end
	end

	// The mean never exceeds 2^23 in magnitude, so 24 bits of quotient hold it.
	assign bias_mag = div_quot[23:0];

	// Radians: round the Q32 product to nearest on the magnitude, then sign.
	assign rad_mag = mul_prod[gyi_pkg::MUL_P_W-1:gyi_pkg::RAD_FRAC]
		+ gyi_pkg::MUL_A_W'(mul_prod[gyi_pkg::RAD_FRAC-1]);
	assign rad_val = yaw_q[31] ? (32'd0 - 32'(rad_mag)) : 32'(rad_mag);

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gyi_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			gyi_pkg::S_IDLE: begin
				if (sample_valid) begin
					state_d = gyi_pkg::S_EXEC;
				end
			end
			gyi_pkg::S_EXEC: begin
				state_d = gyi_pkg::S_RAD;
				case (cur_q.action)
					gyi_pkg::ACT_RATE: begin
						if (integrate) begin
							mul_start = 1'b1;
							state_d   = gyi_pkg::S_MUL;
						end
					end
					gyi_pkg::ACT_END_CAL: begin
						if (cal_count_q != '0) begin
							div_start = 1'b1;
							state_d   = gyi_pkg::S_DIV;
						end
					end
					default: begin
						state_d = gyi_pkg::S_RAD;
					end
				endcase
			end
			gyi_pkg::S_MUL: begin
				if (mul_stat.done) begin
					div_start = 1'b1;
					state_d   = gyi_pkg::S_DIV;
				end
			end
			gyi_pkg::S_DIV: begin
				if (div_stat.done) begin
					state_d = gyi_pkg::S_RAD;
				end
			end
			gyi_pkg::S_RAD: begin
				mul_start = 1'b1;
				state_d   = gyi_pkg::S_RAD_WAIT;
			end
			gyi_pkg::S_RAD_WAIT: begin
				if (mul_stat.done) begin
					state_d = gyi_pkg::S_OUT;
				end
			end
			gyi_pkg::S_OUT: begin
				// The output register takes the result once it is empty or
				// its current transaction leaves in this cycle.
				if (!out_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d  = gyi_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = gyi_pkg::S_IDLE;
			end
		endcase
	end

	assign sample_stall = (state_q != gyi_pkg::S_IDLE);

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			cur_q <= sample;
		end
	end

	// ------------------------------------------------------------------
	// Architectural state updates.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q         <= '0;
			last_stamp_q  <= '0;
			stamp_valid_q <= 1'b0;
			bias_q        <= '0;
			cal_sum_q     <= '0;
			cal_count_q   <= '0;
			status_q      <= gyi_pkg::ST_INTEGRATED;
			neg_q         <= 1'b0;
			rad_q         <= '0;
		end else begin
			case (state_q)
				gyi_pkg::S_EXEC: begin
					case (cur_q.action)
						gyi_pkg::ACT_RATE: begin
							if (!stamp_valid_q) begin
								// A first sample only sets the time base.
								last_stamp_q  <= cur_q.timestamp;
								stamp_valid_q <= 1'b1;
								status_q      <= gyi_pkg::ST_FIRST;
							end else if (too_soon) begin
								status_q <= gyi_pkg::ST_TOO_SOON;
							end else begin
								last_stamp_q <= cur_q.timestamp;
								neg_q        <= diff[24];
								status_q     <= gyi_pkg::ST_INTEGRATED;
							end
						end
						gyi_pkg::ACT_CAL: begin
							// A full count ignores further samples.
							if (!cal_full) begin
								cal_sum_q   <= cal_sum_q + raw_ext;
								cal_count_q <= cal_count_q + 1'b1;
							end
							status_q <= gyi_pkg::ST_CAL_SAMPLE;
						end
						gyi_pkg::ACT_END_CAL: begin
							if (cal_count_q == '0) begin
								status_q <= gyi_pkg::ST_CAL_EMPTY_SET;
							end else begin
								// The divider has taken its operands in
								// this cycle, so the sums can clear now.
								neg_q       <= cal_sum_q[SUM_W-1];
								cal_sum_q   <= '0;
								cal_count_q <= '0;
								status_q    <= gyi_pkg::ST_CAL_DONE;
							end
						end
						gyi_pkg::ACT_SET_YAW: begin
							yaw_q    <= cur_q.yaw_value;
							status_q <= gyi_pkg::ST_CAL_EMPTY_SET;
						end
						default: begin
							status_q <= status_q;
						end
					endcase
				end
				gyi_pkg::S_DIV: begin
					if (div_stat.done) begin
						if (status_q == gyi_pkg::ST_INTEGRATED) begin
							yaw_q <= yaw_sat;
						end else begin
							bias_q <= neg_q ? (24'd0 - bias_mag) : bias_mag;
						end
					end
				end
				gyi_pkg::S_RAD_WAIT: begin
					if (mul_stat.done) begin
						rad_q <= rad_val;
					end
				end
				default: begin
					rad_q <= rad_q;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.yaw_degrees <= yaw_q;
			out_q.yaw_radians <= rad_q;
			out_q.bias        <= bias_q;
			out_q.status      <= status_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`GYI_ASSERT_IMP(a_units_exclusive, 1'b1, !(mul_stat.busy && div_stat.busy))
	`GYI_ASSERT_NEXT(a_accept_decodes, sample_valid && !sample_stall, state_q == gyi_pkg::S_EXEC)
	`GYI_ASSERT_IMP(a_bias_from_divider, !$stable(bias_q), $past(state_q) == gyi_pkg::S_DIV)
	`GYI_ASSERT_IMP(a_result_from_out, $rose(result_valid), $past(state_q) == gyi_pkg::S_OUT)

endmodule

FILE: hw/rtl/gyi_serial_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module gyi_serial_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [gyi_pkg::MUL_A_W-1:0]   a,
	input  logic [gyi_pkg::MUL_B_W-1:0]   b,
	output gyi_pkg::unit_stat_t           stat,
	output logic [gyi_pkg::MUL_P_W-1:0]   product
);

	localparam int A_W   = gyi_pkg::MUL_A_W;
	localparam int B_W   = gyi_pkg::MUL_B_W;
	localparam int CNT_W = $clog2(B_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [A_W-1:0]   a_q;
	logic [A_W-1:0]   hi_q;
	logic [B_W-1:0]   lo_q;
	logic [A_W:0]     sum;
	logic             last_step;

	// The low half shifts the multiplier out as the product shifts in.
	assign sum       = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
	assign last_step = busy_q && (cnt_q == CNT_W'(B_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			{hi_q, lo_q} <= {sum, lo_q[B_W-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = {hi_q, lo_q};

endmodule

FILE: hw/rtl/gyi_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module gyi_serial_div #(
	parameter int NUM_W = gyi_pkg::RATE_NUM_W,
	parameter int DEN_W = gyi_pkg::RATE_DEN_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NUM_W-1:0]   num,
	input  logic [DEN_W-1:0]   den,
	output gyi_pkg::unit_stat_t stat,
	output logic [NUM_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   trial_sub;
	logic             fits;
	logic             last_step;

	// The partial remainder stays below the divisor, so one compare and
	// subtract per bit is enough.
	assign trial     = {rem_q, num_q[NUM_W-1]};
	assign fits      = (trial >= {1'b0, den_q});
	assign trial_sub = trial - {1'b0, den_q};
	assign last_step = busy_q && (cnt_q == CNT_W'(NUM_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// The dividend register fills with quotient bits from the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = num_q;

endmodule
